// ===== src/uerav_pkg.sv =====
// ============================================================================
// uerav_pkg
// shared types and constants for the ultrasonic echo ranging average block
// ============================================================================
`default_nettype none

package uerav_pkg;

    localparam int DATA_W         = 16;
    localparam int TICK_W         = 21;
    localparam int RING_DEPTH_DEF = 8;

    localparam logic [TICK_W-1:0] TIMEOUT_RST = 21'd1000000;
    localparam logic [DATA_W-1:0] MAXD_RST    = 16'd20000;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MAXD    = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_DONE    = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_READ,
        MS_ACC,
        MS_DIV,
        MS_DONE
    } t_mean_state;

    typedef struct packed {
        logic              avg_valid;
        logic [DATA_W-1:0] average;
    } t_mean_res;

endpackage

`default_nettype wire

// ===== src/ultrasonic_echo_ranging_average.sv =====
// ============================================================================
// ultrasonic_echo_ranging_average
// echo pulse width ranging with a ring of recent widths and their mean
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_cmd, i_echo_level
//   output   out        o_valid / i_stall  o_trigger, o_status, o_width,
//                                          o_avg_valid, o_average
//   config   in         apb write / read   timeout_ticks, max_distance
//
// one item at a time: each transfer runs the ring sweep and then the bit-serial
// divide in the shared add/sub unit before its result is registered
// a new item is taken once the mean unit is idle, even while a result waits
// synchronous active-low reset clears phase, counters and ring valid bits
// ============================================================================
`default_nettype none

module ultrasonic_echo_ranging_average
    import uerav_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_cmd,
    input  wire logic              i_echo_level,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_trigger,
    output logic [1:0]             o_status,
    output logic [DATA_W-1:0]      o_width,
    output logic                   o_avg_valid,
    output logic [DATA_W-1:0]      o_average,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int AW = $clog2(RING_DEPTH);

    logic [TICK_W-1:0] r_timeout;
    logic [DATA_W-1:0] r_maxd;

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [AW-1:0]     r_wr_idx;
    logic              r_start;

    logic              r_pend_trig;
    t_status           r_pend_status;
    logic [DATA_W-1:0] r_pend_width;

    logic              r_out_valid;
    logic              r_out_trig;
    logic [1:0]        r_out_status;
    logic [DATA_W-1:0] r_out_width;
    t_mean_res         r_out_mean;

    logic              w_in_xfer;
    logic              w_cfg_wr;
    logic [TICK_W-1:0] w_tick_inc;
    logic [TICK_W-1:0] w_tick_new;
    logic [DATA_W-1:0] w_clamped;
    t_status           w_status;
    logic [DATA_W-1:0] w_width;
    logic              w_ring_wr;

    logic [AW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;
    logic              w_rd_vld;
    logic              w_mean_busy;
    logic              w_mean_done;
    logic              w_take;
    t_mean_res         w_mean_res;

    assign w_in_xfer = i_valid && !o_stall;
    assign o_stall   = w_mean_busy || r_start;
    assign w_take    = !r_out_valid || !i_stall;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_TIMEOUT: prdata = 32'(r_timeout);
            REG_MAXD:    prdata = 32'(r_maxd);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_maxd    <= MAXD_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_TIMEOUT) begin
                r_timeout <= pwdata[TICK_W-1:0];
            end else begin
                r_maxd <= pwdata[DATA_W-1:0];
            end
        end
    end

    // echo phase tracking
    assign w_tick_inc = r_tick + 1'b1;
    assign w_tick_new = (r_phase == PH_WAIT && i_echo_level) ? TICK_W'(1) : w_tick_inc;
    assign w_clamped  = (r_tick > TICK_W'(r_maxd)) ? r_maxd : r_tick[DATA_W-1:0];

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        if (i_cmd) begin
            n_phase = PH_WAIT;
            n_tick  = '0;
        end else begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (w_tick_new >= r_timeout) begin
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                    end else begin
                        n_phase = i_echo_level ? PH_HIGH : PH_WAIT;
                        n_tick  = w_tick_new;
                    end
                end
                PH_HIGH: begin
                    if (!i_echo_level || w_tick_new >= r_timeout) begin
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                    end else begin
                        n_tick = w_tick_new;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        w_status  = ST_NONE;
        w_width   = '0;
        w_ring_wr = 1'b0;
        if (!i_cmd) begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (w_tick_new >= r_timeout) w_status = ST_TIMEOUT;
                end
                PH_HIGH: begin
                    if (!i_echo_level) begin
                        w_status  = ST_DONE;
                        w_width   = w_clamped;
                        w_ring_wr = w_in_xfer;
                    end else if (w_tick_new >= r_timeout) begin
                        w_status = ST_TIMEOUT;
                    end
                end
                default: begin
                    w_status = ST_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tick   <= '0;
            r_wr_idx <= '0;
            r_start  <= 1'b0;
        end else begin
            r_start <= w_in_xfer;
            if (w_in_xfer) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
            end
            if (w_ring_wr) begin
                r_wr_idx <= (r_wr_idx == AW'(RING_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_pend_trig   <= i_cmd;
            r_pend_status <= w_status;
            r_pend_width  <= w_width;
        end
    end

    uerav_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_ring_wr),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (w_clamped),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .o_rd_vld  (w_rd_vld)
    );

    uerav_mean #(
        .RING_DEPTH (RING_DEPTH)
    ) u_mean (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (r_start),
        .i_max_distance (r_maxd),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data),
        .i_rd_vld       (w_rd_vld),
        .o_busy         (w_mean_busy),
        .o_done         (w_mean_done),
        .i_take         (w_take),
        .o_res          (w_mean_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_mean_done && w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mean_done && w_take) begin
            r_out_trig   <= r_pend_trig;
            r_out_status <= r_pend_status;
            r_out_width  <= r_pend_width;
            r_out_mean   <= w_mean_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_trigger   = r_out_trig;
    assign o_status    = r_out_status;
    assign o_width     = r_out_width;
    assign o_avg_valid = r_out_mean.avg_valid;
    assign o_average   = r_out_mean.average;

    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_cmd) |=> (r_phase == PH_WAIT && r_tick == '0))
        else $error("start transfer did not arm the rise wait");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_stall)
        else $error("input taken while previous item still in flight");

    a_no_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_avg_valid) |-> (o_average == '0))
        else $error("average nonzero without valid entries");

    a_width_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_DONE) |-> (o_width == '0))
        else $error("width set on a result that is not a completed measurement");

    a_width_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DONE) |-> (o_width <= r_maxd))
        else $error("completed width above max distance");

endmodule

`default_nettype wire

// ===== src/uerav_ring.sv =====
// ============================================================================
// uerav_ring
// sample ring memory with per-entry valid bits and registered read
// ============================================================================
`default_nettype none

module uerav_ring
    import uerav_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [$clog2(RING_DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]             i_wr_data,
    input  wire logic [$clog2(RING_DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]             o_rd_data,
    output logic                               o_rd_vld
);

    logic [DATA_W-1:0]     r_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_vld;
    logic [DATA_W-1:0]     r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_vld  = r_rd_vld;

endmodule

`default_nettype wire

// ===== src/uerav_mean.sv =====
// ============================================================================
// uerav_mean
// ring mean sequencer: one shared add/sub unit sums nonzero valid entries
// up to max distance, then runs a restoring divide one quotient bit per cycle
// ============================================================================
`default_nettype none

module uerav_mean
    import uerav_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [DATA_W-1:0]             i_max_distance,
    output logic      [$clog2(RING_DEPTH)-1:0] o_rd_addr,
    input  wire logic [DATA_W-1:0]             i_rd_data,
    input  wire logic                          i_rd_vld,
    output logic                               o_busy,
    output logic                               o_done,
    input  wire logic                          i_take,
    output t_mean_res                          o_res
);

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = DATA_W + AW;
    localparam int STEP_W = $clog2(SUM_W);

    t_mean_state       r_state, n_state;
    logic [AW-1:0]     r_idx, n_idx;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;

    logic [CNT_W:0]    w_shift;
    logic [SUM_W:0]    w_op_a, w_op_b, w_alu;
    logic              w_op_sub;
    logic              w_counts;
    logic              w_last;
    logic              w_qbit;

    // shared add/sub unit
    always_comb begin
        w_shift  = {r_rem, r_sum[SUM_W-1]};
        w_op_sub = (r_state == MS_DIV);
        if (w_op_sub) begin
            w_op_a = (SUM_W+1)'(w_shift);
            w_op_b = (SUM_W+1)'(r_cnt);
        end else begin
            w_op_a = {1'b0, r_sum};
            w_op_b = (SUM_W+1)'(i_rd_data);
        end
        w_alu = w_op_sub ? (w_op_a - w_op_b) : (w_op_a + w_op_b);
    end

    assign w_counts = i_rd_vld && (i_rd_data != '0) && (i_rd_data <= i_max_distance);
    assign w_last   = (r_idx == AW'(RING_DEPTH - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MS_IDLE: if (i_start) n_state = MS_READ;
            MS_READ: n_state = MS_ACC;
            MS_ACC:  n_state = w_last ? MS_DIV : MS_READ;
            MS_DIV:  if (r_step == STEP_W'(SUM_W - 1)) n_state = MS_DONE;
            MS_DONE: if (i_take) n_state = MS_IDLE;
            default: n_state = MS_IDLE;
        endcase
    end

    always_comb begin
        n_idx  = r_idx;
        n_sum  = r_sum;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_step = r_step;
        w_qbit = 1'b0;
        unique case (r_state)
            MS_IDLE: begin
                n_idx  = '0;
                n_sum  = '0;
                n_cnt  = '0;
                n_rem  = '0;
                n_step = '0;
            end
            MS_ACC: begin
                if (w_counts) begin
                    n_sum = w_alu[SUM_W-1:0];
                    n_cnt = r_cnt + 1'b1;
                end
                if (!w_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            MS_DIV: begin
                n_step = r_step + 1'b1;
                if (!w_alu[SUM_W]) begin
                    n_rem  = w_alu[CNT_W-1:0];
                    w_qbit = 1'b1;
                end else begin
                    n_rem  = w_shift[CNT_W-1:0];
                end
                n_sum = {r_sum[SUM_W-2:0], w_qbit};
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_sum  <= n_sum;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_step <= n_step;
    end

    assign o_rd_addr       = r_idx;
    assign o_busy          = (r_state != MS_IDLE);
    assign o_done          = (r_state == MS_DONE);
    assign o_res.avg_valid = (r_cnt != '0);
    assign o_res.average   = (r_cnt != '0) ? r_sum[DATA_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top
// Testbench for ultrasonic_echo_ranging_average. Start and tick transfers go
// in over valid/stall, and every result is compared field by field with an
// in-bench model of the ranging phases, the width ring and the ring mean, or
// with the values given in checked rows. A short directed table covers the
// extremes, timeouts and clamping. Random phases at varied register settings
// follow and send mostly well-formed echo pulses. Both sides idle at random.
// ============================================================================

module tb_top;
    import uerav_pkg::*;

    localparam int DEPTH       = RING_DEPTH_DEF;
    localparam int RAND_ITEMS  = 1550;
    localparam int PHASE_ITEMS = 130;

    typedef struct packed {
        logic              trig;
        t_status           status;
        logic [DATA_W-1:0] width;
        logic              avg_valid;
        logic [DATA_W-1:0] average;
    } t_echo_res;

    typedef enum bit {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        reg_idx;
        logic [31:0] data;
        logic        cmd;
        logic        echo;
        logic        typed;
        t_echo_res   want;
    } t_row;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              i_cmd        = 1'b0;
    logic              i_echo_level = 1'b0;
    logic              i_stall      = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [2:0]        paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic              o_stall;
    logic              o_valid;
    logic              o_trigger;
    logic [1:0]        o_status;
    logic [DATA_W-1:0] o_width;
    logic              o_avg_valid;
    logic [DATA_W-1:0] o_average;
    logic [31:0]       prdata;
    logic              pready;

    // model state
    t_phase            ph_m;
    logic [TICK_W-1:0] cnt_m;
    logic [DATA_W-1:0] ring_m [DEPTH];
    int                widx_m;
    logic [TICK_W-1:0] tmo_m;
    logic [DATA_W-1:0] maxd_m;

    t_echo_res   pending_echo [$];
    t_row        dir_rows [$];
    int unsigned mismatch_cnt = 0;
    int unsigned sent_items   = 0;
    bit          calm = 1'b0;

    ultrasonic_echo_ranging_average dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_echo_level (i_echo_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_trigger    (o_trigger),
        .o_status     (o_status),
        .o_width      (o_width),
        .o_avg_valid  (o_avg_valid),
        .o_average    (o_average),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_echo_res res(logic trig, t_status st, logic [DATA_W-1:0] w,
                                      logic av, logic [DATA_W-1:0] avg);
        t_echo_res r;
        r.trig      = trig;
        r.status    = st;
        r.width     = w;
        r.avg_valid = av;
        r.average   = avg;
        return r;
    endfunction

    function automatic t_row row_item(logic cmd, logic echo);
        t_row r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.cmd  = cmd;
        r.echo = echo;
        return r;
    endfunction

    function automatic t_row row_check(logic cmd, logic echo, t_echo_res want);
        t_row r;
        r       = row_item(cmd, echo);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_row row_write(logic idx, logic [31:0] data);
        t_row r;
        r         = '0;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.data    = data;
        return r;
    endfunction

    function automatic t_echo_res ranging_step(input logic cmd, input logic echo);
        t_echo_res         r;
        logic [TICK_W-1:0] w;
        logic [31:0]       sum;
        int                n;
        r        = '0;
        r.status = ST_NONE;
        if (cmd) begin
            r.trig = 1'b1;
            ph_m   = PH_WAIT;
            cnt_m  = '0;
        end else if (ph_m == PH_WAIT) begin
            if (echo) begin
                ph_m  = PH_HIGH;
                cnt_m = TICK_W'(1);
            end else begin
                cnt_m = cnt_m + 1'b1;
            end
            if (cnt_m >= tmo_m) begin
                r.status = ST_TIMEOUT;
                ph_m     = PH_IDLE;
                cnt_m    = '0;
            end
        end else if (ph_m == PH_HIGH) begin
            if (echo) begin
                cnt_m = cnt_m + 1'b1;
                if (cnt_m >= tmo_m) begin
                    r.status = ST_TIMEOUT;
                    ph_m     = PH_IDLE;
                    cnt_m    = '0;
                end
            end else begin
                w              = (cnt_m > TICK_W'(maxd_m)) ? TICK_W'(maxd_m) : cnt_m;
                ring_m[widx_m] = w[DATA_W-1:0];
                widx_m         = (widx_m + 1) % DEPTH;
                r.status       = ST_DONE;
                r.width        = w[DATA_W-1:0];
                ph_m           = PH_IDLE;
                cnt_m          = '0;
            end
        end
        sum = 0;
        n   = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (ring_m[i] != 0 && ring_m[i] <= maxd_m) begin
                sum = sum + ring_m[i];
                n   = n + 1;
            end
        end
        if (n != 0) begin
            r.avg_valid = 1'b1;
            r.average   = DATA_W'(sum / n);
        end
        return r;
    endfunction

    task automatic send_item(input logic cmd, input logic echo, input logic typed,
                             input t_echo_res want);
        t_echo_res pred;
        if (!calm && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_echo_level <= echo;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_items++;
        pred = ranging_step(cmd, echo);
        pending_echo.push_back(typed ? want : pred);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_echo.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TIMEOUT) tmo_m = data[TICK_W-1:0];
        else maxd_m = data[DATA_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic run_pulse();
        int n;
        if ($urandom_range(0, 99) < 85) begin
            send_item(1'b1, 1'($urandom), 1'b0, '0);
            n = $urandom_range(0, 8);
            repeat (n) send_item(1'b0, 1'b0, 1'b0, '0);
            n = $urandom_range(1, 40);
            repeat (n) send_item(1'b0, 1'b1, 1'b0, '0);
            send_item(1'b0, 1'b0, 1'b0, '0);
        end else begin
            n = $urandom_range(1, 10);
            repeat (n) send_item($urandom_range(0, 3) == 0, 1'($urandom), 1'b0, '0);
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 40)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_echo_res want;
        i_stall <= !calm && ($urandom_range(0, 99) < 7);
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_echo.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 40)
                    $display("%0t: unexpected transfer, expected none actual status %0d",
                             $time, o_status);
            end else begin
                want = pending_echo.pop_front();
                compare_field("trigger", want.trig, o_trigger);
                compare_field("status", want.status, o_status);
                compare_field("width", want.width, o_width);
                compare_field("avg_valid", want.avg_valid, o_avg_valid);
                compare_field("average", want.average, o_average);
            end
        end
    end

    initial begin
        int          phase_no;
        int unsigned mark;
        logic [31:0] tmo_val;
        logic [31:0] maxd_val;

        ph_m   = PH_IDLE;
        cnt_m  = '0;
        widx_m = 0;
        tmo_m  = TIMEOUT_RST;
        maxd_m = MAXD_RST;
        for (int i = 0; i < DEPTH; i++) ring_m[i] = '0;

        // idle ticks, echo ignored on start, first pulse
        dir_rows.push_back(row_check(1'b0, 1'b0, res(0, ST_NONE, 0, 0, 0)));
        dir_rows.push_back(row_check(1'b0, 1'b1, res(0, ST_NONE, 0, 0, 0)));
        dir_rows.push_back(row_check(1'b1, 1'b1, res(1, ST_NONE, 0, 0, 0)));
        dir_rows.push_back(row_check(1'b0, 1'b1, res(0, ST_NONE, 0, 0, 0)));
        dir_rows.push_back(row_item(1'b0, 1'b1));
        dir_rows.push_back(row_check(1'b0, 1'b0, res(0, ST_DONE, 2, 1, 2)));
        // restart while busy
        dir_rows.push_back(row_item(1'b1, 1'b0));
        dir_rows.push_back(row_item(1'b0, 1'b0));
        dir_rows.push_back(row_item(1'b1, 1'b0));
        dir_rows.push_back(row_item(1'b0, 1'b1));
        dir_rows.push_back(row_item(1'b0, 1'b1));
        dir_rows.push_back(row_item(1'b0, 1'b0));
        // clamp to smallest max distance
        dir_rows.push_back(row_write(REG_MAXD, 32'd1));
        dir_rows.push_back(row_item(1'b1, 1'b0));
        dir_rows.push_back(row_item(1'b0, 1'b1));
        dir_rows.push_back(row_item(1'b0, 1'b1));
        dir_rows.push_back(row_check(1'b0, 1'b0, res(0, ST_DONE, 1, 1, 1)));
        // timeouts in the rise wait, with the echo low and high
        dir_rows.push_back(row_write(REG_TIMEOUT, 32'd1));
        dir_rows.push_back(row_item(1'b1, 1'b0));
        dir_rows.push_back(row_check(1'b0, 1'b0, res(0, ST_TIMEOUT, 0, 1, 1)));
        dir_rows.push_back(row_item(1'b1, 1'b0));
        dir_rows.push_back(row_check(1'b0, 1'b1, res(0, ST_TIMEOUT, 0, 1, 1)));
        dir_rows.push_back(row_write(REG_TIMEOUT, 32'd0));
        dir_rows.push_back(row_item(1'b1, 1'b1));
        dir_rows.push_back(row_check(1'b0, 1'b0, res(0, ST_TIMEOUT, 0, 1, 1)));
        // zero max distance hides every entry
        dir_rows.push_back(row_write(REG_MAXD, 32'd0));
        dir_rows.push_back(row_check(1'b0, 1'b0, res(0, ST_NONE, 0, 0, 0)));
        // largest settings
        dir_rows.push_back(row_write(REG_TIMEOUT, 32'd2097151));
        dir_rows.push_back(row_write(REG_MAXD, 32'd65535));
        dir_rows.push_back(row_item(1'b1, 1'b0));
        dir_rows.push_back(row_item(1'b0, 1'b1));
        dir_rows.push_back(row_item(1'b0, 1'b0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_WRITE) begin
                settle();
                cfg_write(dir_rows[k].reg_idx, dir_rows[k].data);
            end else begin
                send_item(dir_rows[k].cmd, dir_rows[k].echo, dir_rows[k].typed,
                          dir_rows[k].want);
            end
        end

        sent_items = 0;
        phase_no   = 0;
        while (sent_items < RAND_ITEMS) begin
            settle();
            case (phase_no % 6)
                0: begin
                    tmo_val  = $urandom_range(1, 40);
                    maxd_val = $urandom_range(1, 30);
                end
                1: begin
                    tmo_val  = $urandom_range(1, 12);
                    maxd_val = $urandom_range(1, 8);
                end
                2: begin
                    tmo_val  = 32'd2097151;
                    maxd_val = 32'd65535;
                end
                3: begin
                    tmo_val  = $urandom;
                    maxd_val = $urandom;
                end
                4: begin
                    tmo_val  = $urandom_range(0, 1);
                    maxd_val = $urandom_range(0, 1);
                end
                default: begin
                    tmo_val  = $urandom_range(8, 60);
                    maxd_val = $urandom_range(0, 45);
                end
            endcase
            cfg_write(REG_TIMEOUT, tmo_val);
            cfg_write(REG_MAXD, maxd_val);
            // one whole phase with no idling on either side
            calm = (phase_no == 2);
            mark = sent_items;
            while (sent_items - mark < PHASE_ITEMS) run_pulse();
            phase_no++;
        end
        calm = 1'b0;

        i_valid <= 1'b0;
        while (pending_echo.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/uerav_pkg.sv
src/uerav_ring.sv
src/uerav_mean.sv
src/ultrasonic_echo_ranging_average.sv
tb/tb_top.sv
